// ===== sv/pdkt_pkg.sv =====
package pdkt_pkg;

    // default pool size and number of device slots served
    localparam int PDKT_ENTRIES = 32;
    localparam int PDKT_DEVICES = 16;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ADDED   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // field widths
    localparam int DEV_W = 4;
    localparam int NUM_W = 8;
    localparam int KEY_W = 64;

    // one pool row: owner, key number, upper key half, lower key half (from bit 0 up)
    localparam int ROW_DEV_LO = 0;
    localparam int ROW_NUM_LO = ROW_DEV_LO + DEV_W;
    localparam int ROW_KU_LO  = ROW_NUM_LO + NUM_W;
    localparam int ROW_KL_LO  = ROW_KU_LO + KEY_W;
    localparam int ROW_W      = ROW_KL_LO + KEY_W;

endpackage

// ===== sv/pdkt_ram.sv =====
module pdkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/per_device_key_table_unit.sv =====
// Key table: a shared pool of ENTRIES slots, each holding one 128-bit key
// tagged by owning device slot and 8-bit key number. An item on the slave
// stream is a lookup, a set or a remove (operation code in tuser); each item
// gives exactly one result item on the master stream with a status and, for a
// lookup hit, the stored key. The tags and keys live in one synchronous RAM
// read once per cycle; the per-slot valid bits are flip-flops cleared by
// reset, so the block is ready straight after reset with no clearing pass.
// A lookup, set or remove on a served device scans the whole pool, one slot a
// cycle through the RAM read port, and then checks the last row read; a decide
// state then fixes the status and, for a set, writes the row back, and a
// deliver state hands the result to the output register. An unused operation
// code or a device slot beyond the served range skips the scan, changes
// nothing and returns not found. A new item is taken as soon as the previous
// result sits in the output register, so the block only stalls if that
// register is still full when the next result is ready. A set with no match
// takes the lowest free slot.
module per_device_key_table_unit
    import pdkt_pkg::*;
#(
    parameter int ENTRIES = PDKT_ENTRIES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [143:0] i_s_tdata,  // device_slot, key_number, key_upper, key_lower
    input  logic [1:0]   i_s_tuser,  // kind
    // master stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata   // status, found_upper, found_lower
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_DECIDE  = 2'd2;
    localparam logic [1:0] S_DELIVER = 2'd3;

    // control registers
    logic [1:0]         r_state,   n_state;
    logic [ENTRIES-1:0] r_valid,   n_valid;
    logic               r_pend,    n_pend;
    logic               r_out_vld, n_out_vld;

    // working registers of the current item
    logic [CW-1:0]      r_idx,      n_idx;
    logic [IW-1:0]      r_pidx,     n_pidx;
    logic               r_hit,      n_hit;
    logic [IW-1:0]      r_hit_idx,  n_hit_idx;
    logic               r_free,     n_free;
    logic [IW-1:0]      r_free_idx, n_free_idx;
    logic [2*KEY_W-1:0] r_hit_key,  n_hit_key;
    logic               r_bad,      n_bad;
    logic [1:0]         r_kind,     n_kind;
    logic [DEV_W-1:0]   r_dev,      n_dev;
    logic [NUM_W-1:0]   r_num,      n_num;
    logic [KEY_W-1:0]   r_ku,       n_ku;
    logic [KEY_W-1:0]   r_kl,       n_kl;
    logic [1:0]         r_status,   n_status;
    logic [KEY_W-1:0]   r_fu,       n_fu;
    logic [KEY_W-1:0]   r_fl,       n_fl;
    logic [135:0]       r_out_data, n_out_data;

    // pool memory port
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic             tag_match;

    pdkt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // a row written back always carries the current item's tag and key
    assign ram_wdata = {r_kl, r_ku, r_num, r_dev};

    // row read in the previous cycle against the item's tag
    assign tag_match = r_valid[r_pidx]
                    && (ram_rdata[ROW_DEV_LO +: DEV_W] == r_dev)
                    && (ram_rdata[ROW_NUM_LO +: NUM_W] == r_num);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_hit_key  = r_hit_key;
        n_bad      = r_bad;
        n_kind     = r_kind;
        n_dev      = r_dev;
        n_num      = r_num;
        n_ku       = r_ku;
        n_kl       = r_kl;
        n_status   = r_status;
        n_fu       = r_fu;
        n_fl       = r_fl;
        n_out_data = r_out_data;
        ram_we     = 1'b0;
        ram_waddr  = r_hit_idx;

        // result taken downstream
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind  = i_s_tuser;
                    n_dev   = i_s_tdata[3:0];
                    n_num   = i_s_tdata[11:4];
                    n_ku    = i_s_tdata[75:12];
                    n_kl    = i_s_tdata[139:76];
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    // unused operation or device out of range: no scan, not found
                    n_bad   = (i_s_tuser != OP_LOOKUP && i_s_tuser != OP_SET
                               && i_s_tuser != OP_REMOVE)
                           || ({5'd0, i_s_tdata[3:0]} >= 9'(PDKT_DEVICES));
                    n_state = n_bad ? S_DECIDE : S_SCAN;
                end
            end

            S_SCAN: begin
                // compare the row that arrived from the memory
                if (r_pend) begin
                    if (tag_match && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_pidx;
                        n_hit_key = ram_rdata[ROW_KU_LO +: 2*KEY_W];
                    end
                    if (!r_valid[r_pidx] && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_pidx;
                    end
                end
                // issue the next read, or finish once the last row is checked
                if (r_idx != CW'(ENTRIES)) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DECIDE;
                    end
                end
            end

            S_DECIDE: begin
                n_status = ST_MISSING;
                n_fu     = '0;
                n_fl     = '0;
                if (!r_bad) begin
                    case (r_kind)
                        OP_LOOKUP: begin
                            if (r_hit) begin
                                n_status = ST_OK;
                                n_fu     = r_hit_key[KEY_W-1:0];
                                n_fl     = r_hit_key[2*KEY_W-1:KEY_W];
                            end
                        end
                        OP_SET: begin
                            if (r_hit) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_hit_idx;
                                n_status  = ST_OK;
                            end else if (r_free) begin
                                ram_we              = 1'b1;
                                ram_waddr           = r_free_idx;
                                n_valid[r_free_idx] = 1'b1;
                                n_status            = ST_ADDED;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_status           = ST_OK;
                            end
                        end
                        default: begin
                            n_status = ST_MISSING;
                        end
                    endcase
                end
                n_state = S_DELIVER;
            end

            S_DELIVER: begin
                // wait for the output register to be free
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {6'd0, r_fl, r_fu, r_status};
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_hit_key  <= n_hit_key;
        r_bad      <= n_bad;
        r_kind     <= n_kind;
        r_dev      <= n_dev;
        r_num      <= n_num;
        r_ku       <= n_ku;
        r_kl       <= n_kl;
        r_status   <= n_status;
        r_fu       <= n_fu;
        r_fl       <= n_fl;
        r_out_data <= n_out_data;
    end

endmodule

// ===== dv/pdkt_key_checker.sv =====
module pdkt_key_checker
    import pdkt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [143:0] i_s_tdata,  // device_slot, key_number, key_upper, key_lower
    input  logic [1:0]   i_s_tuser,  // kind
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,  // status, found_upper, found_lower
    output int           o_fail_count,
    output int           o_pending,
    output int           o_hit_count,
    output int           o_full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] upper;
        logic [KEY_W-1:0] lower;
    } t_key_result;

    // shadow copy of the key pool
    logic             slot_valid  [PDKT_ENTRIES];
    logic [DEV_W-1:0] slot_owner  [PDKT_ENTRIES];
    logic [NUM_W-1:0] slot_number [PDKT_ENTRIES];
    logic [KEY_W-1:0] slot_key_hi [PDKT_ENTRIES];
    logic [KEY_W-1:0] slot_key_lo [PDKT_ENTRIES];

    t_key_result key_results_due[$];
    int          fail_total;
    int          hit_total;
    int          full_total;

    assign o_fail_count = fail_total;
    assign o_hit_count  = hit_total;
    assign o_full_count = full_total;

    // one table operation: updates the shadow pool, gives the expected result
    task automatic apply_key_op(input logic [1:0] kind, input logic [DEV_W-1:0] dev,
                                input logic [NUM_W-1:0] num, input logic [KEY_W-1:0] ku,
                                input logic [KEY_W-1:0] kl, output t_key_result res);
        int match_slot;
        int free_slot;
        res.status = ST_MISSING;
        res.upper  = '0;
        res.lower  = '0;
        if (int'(dev) >= PDKT_DEVICES) begin
            return;
        end
        match_slot = -1;
        free_slot  = -1;
        for (int i = 0; i < PDKT_ENTRIES; i++) begin
            if (slot_valid[i] && slot_owner[i] == dev && slot_number[i] == num
                && match_slot < 0) begin
                match_slot = i;
            end
            if (!slot_valid[i] && free_slot < 0) begin
                free_slot = i;
            end
        end
        case (kind)
            OP_LOOKUP: begin
                if (match_slot >= 0) begin
                    res.status = ST_OK;
                    res.upper  = slot_key_hi[match_slot];
                    res.lower  = slot_key_lo[match_slot];
                end
            end
            OP_SET: begin
                if (match_slot >= 0) begin
                    slot_key_hi[match_slot] = ku;
                    slot_key_lo[match_slot] = kl;
                    res.status = ST_OK;
                end else if (free_slot >= 0) begin
                    slot_valid[free_slot]  = 1'b1;
                    slot_owner[free_slot]  = dev;
                    slot_number[free_slot] = num;
                    slot_key_hi[free_slot] = ku;
                    slot_key_lo[free_slot] = kl;
                    res.status = ST_ADDED;
                end else begin
                    res.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (match_slot >= 0) begin
                    slot_valid[match_slot] = 1'b0;
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_key_result got;
        t_key_result want;
        t_key_result fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < PDKT_ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
            end
            key_results_due.delete();
        end else begin
            // results first: they belong to items taken on earlier edges
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tdata[1:0];
                got.upper  = i_m_tdata[65:2];
                got.lower  = i_m_tdata[129:66];
                if (key_results_due.size() == 0) begin
                    $error("result item with nothing pending: status %0d", got.status);
                    fail_total++;
                end else begin
                    want = key_results_due.pop_front();
                    if (got.status != want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fail_total++;
                    end
                    if (got.upper != want.upper) begin
                        $error("found_upper mismatch: expected %h, actual %h",
                               want.upper, got.upper);
                        fail_total++;
                    end
                    if (got.lower != want.lower) begin
                        $error("found_lower mismatch: expected %h, actual %h",
                               want.lower, got.lower);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_key_op(i_s_tuser, i_s_tdata[3:0], i_s_tdata[11:4],
                             i_s_tdata[75:12], i_s_tdata[139:76], fresh);
                if (i_s_tuser == OP_LOOKUP && fresh.status == ST_OK) begin
                    hit_total++;
                end
                if (fresh.status == ST_FULL) begin
                    full_total++;
                end
                key_results_due.push_back(fresh);
            end
        end
        o_pending <= key_results_due.size();
    end

endmodule

// ===== dv/tb_per_device_key_table_unit.sv =====
module tb_per_device_key_table_unit;
    import pdkt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // the spare operation code, which must leave the pool untouched
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS  = 1750;
    localparam int TAIL_ITEMS   = 150;   // closing stretch run without idling
    localparam int STALL_LIMIT  = 4000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 60;    // settle time after the last result
    localparam int HOT_MAX      = 48;

    logic         i_clk;
    logic         rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [143:0] s_data;   // device_slot, key_number, key_upper, key_lower
    logic [1:0]   s_kind;   // kind
    logic         m_valid;
    logic         m_ready;
    logic [135:0] m_data;   // status, found_upper, found_lower

    int fail_count;
    int pending;
    int hit_count;
    int full_count;

    // stimulus bookkeeping
    int  kind_sent [4];
    int  items_sent;
    int  idle_cycles;
    bit  s_idle_on;
    bit  m_idle_on;
    bit  quiet_tail;

    // working set of tags, so that sets, lookups and removes meet each other
    logic [DEV_W-1:0] hot_dev [HOT_MAX];
    logic [NUM_W-1:0] hot_num [HOT_MAX];
    int               hot_n;

    per_device_key_table_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_kind),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)
    );

    pdkt_key_checker u_key_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_kind),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hit_count  (hit_count),
        .o_full_count (full_count)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // watchdog: a run where nothing moves for too long has hung
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: ready with random stall bursts, none in the closing stretch
    initial begin
        m_ready <= 1'b0;
        @(posedge i_clk);
        while (!rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (m_idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // offer one item, optionally after an idle burst, and wait for it to be taken
    task automatic send_key_op(input logic [1:0] kind, input logic [DEV_W-1:0] dev,
                               input logic [NUM_W-1:0] num, input logic [KEY_W-1:0] ku,
                               input logic [KEY_W-1:0] kl);
        if (s_idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= {4'b0, kl, ku, num, dev};
        @(posedge i_clk);
        while (!s_ready) begin
            @(posedge i_clk);
        end
        kind_sent[kind]++;
        items_sent++;
    endtask

    // hold the sender off until every result has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [1:0]       kind;
        logic [DEV_W-1:0] dev;
        logic [NUM_W-1:0] num;
        int               phase_left;
        int               phase_mode;
        int               pick;
        int               set_pct;
        int               lookup_pct;
        int               remove_pct;

        rst_n      <= 1'b0;
        s_valid    <= 1'b0;
        s_kind     <= OP_LOOKUP;
        s_data     <= '0;
        s_idle_on  = 1'b0;
        m_idle_on  = 1'b0;
        quiet_tail = 1'b0;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed: empty pool, field extremes, update, unused code, remove
        send_key_op(OP_LOOKUP, 4'd0, 8'd0, rand_key(), rand_key());
        send_key_op(OP_REMOVE, 4'd15, 8'd255, rand_key(), rand_key());
        send_key_op(OP_SET, 4'd0, 8'd0, '0, '0);
        send_key_op(OP_SET, 4'd15, 8'd255, '1, '1);
        send_key_op(OP_LOOKUP, 4'd15, 8'd255, '0, '0);
        send_key_op(OP_LOOKUP, 4'd0, 8'd0, '1, '1);
        send_key_op(OP_SET, 4'd15, 8'd255, {16{4'hA}}, {16{4'h5}});
        send_key_op(OP_LOOKUP, 4'd15, 8'd255, '0, '0);
        // same owner or same number alone must not match
        send_key_op(OP_LOOKUP, 4'd15, 8'd0, '0, '0);
        send_key_op(OP_LOOKUP, 4'd0, 8'd255, '0, '0);
        // unused operation code on a stored tag leaves it in place
        send_key_op(OP_UNUSED, 4'd0, 8'd0, '1, '1);
        send_key_op(OP_UNUSED, 4'd7, 8'd128, rand_key(), rand_key());
        send_key_op(OP_LOOKUP, 4'd0, 8'd0, '0, '0);
        send_key_op(OP_REMOVE, 4'd0, 8'd0, '0, '0);
        send_key_op(OP_LOOKUP, 4'd0, 8'd0, '0, '0);
        send_key_op(OP_REMOVE, 4'd0, 8'd0, '0, '0);
        // freed slot is reused by the next new tag
        send_key_op(OP_SET, 4'd9, 8'd77, rand_key(), rand_key());
        send_key_op(OP_LOOKUP, 4'd9, 8'd77, '0, '0);
        hold_until_drained();

        // random phases: fill, drain or mixed traffic over a changing working set
        hot_n = 0;
        for (int i = 0; i < HOT_MAX; i++) begin
            hot_dev[i] = DEV_W'($urandom_range(0, 15));
            hot_num[i] = NUM_W'($urandom_range(0, 255));
        end
        phase_left = 0;
        set_pct    = 0;
        lookup_pct = 0;
        remove_pct = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (phase_left == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    hold_until_drained();
                end
                phase_left = $urandom_range(50, 250);
                phase_mode = $urandom_range(0, 2);
                hot_n      = $urandom_range(4, HOT_MAX);
                s_idle_on  = $urandom_range(0, 2) != 0;
                m_idle_on  = $urandom_range(0, 2) != 0;
                // keep about half the tags so stored keys outlive the phase
                for (int i = 0; i < HOT_MAX; i++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        hot_dev[i] = DEV_W'($urandom_range(0, 15));
                        hot_num[i] = NUM_W'($urandom_range(0, 255));
                    end
                end
                case (phase_mode)
                    0: begin  // fill towards a full pool
                        set_pct = 60; lookup_pct = 25; remove_pct = 10;
                    end
                    1: begin  // drain
                        set_pct = 15; lookup_pct = 30; remove_pct = 50;
                    end
                    default: begin
                        set_pct = 35; lookup_pct = 35; remove_pct = 25;
                    end
                endcase
            end
            if (items_sent >= TOTAL_ITEMS - TAIL_ITEMS) begin
                quiet_tail = 1'b1;
            end

            pick = $urandom_range(0, 99);
            if (pick < set_pct) begin
                kind = OP_SET;
            end else if (pick < set_pct + lookup_pct) begin
                kind = OP_LOOKUP;
            end else if (pick < set_pct + lookup_pct + remove_pct) begin
                kind = OP_REMOVE;
            end else begin
                kind = OP_UNUSED;
            end

            // mostly tags from the working set, some anywhere in the tag space
            if ($urandom_range(0, 99) < 85) begin
                pick = $urandom_range(0, hot_n - 1);
                dev  = hot_dev[pick];
                num  = hot_num[pick];
            end else begin
                dev = DEV_W'($urandom_range(0, 15));
                num = NUM_W'($urandom_range(0, 255));
            end

            send_key_op(kind, dev, num, rand_key(), rand_key());
            phase_left--;
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d items: %0d lookups, %0d sets, %0d removes, %0d unused-code",
                 items_sent, kind_sent[OP_LOOKUP], kind_sent[OP_SET],
                 kind_sent[OP_REMOVE], kind_sent[OP_UNUSED]);
        $display("lookup hits %0d, sets refused on a full pool %0d, mismatches %0d",
                 hit_count, full_count, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pdkt_pkg.sv
sv/pdkt_ram.sv
sv/per_device_key_table_unit.sv
dv/pdkt_key_checker.sv
dv/tb_per_device_key_table_unit.sv
